// File: rtl/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, widths, register indexes and gain tables of the stereo
// crossfeed mixer.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int MAX_DELAY_DEF   = 512;
    localparam int SAMPLE_BITS_DEF = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd4;

    localparam int LEN_W   = 10;
    localparam int COEF_W  = 16;

    // shared multiplier: 33b signed by 17b signed
    localparam int LP_W    = 32;
    localparam int MA_W    = LP_W + 1;
    localparam int MB_W    = COEF_W + 1;
    localparam int PROD_W  = MA_W + MB_W;

    localparam logic [COEF_W-1:0] STRENGTH_ONE   = 16'd32768;
    localparam logic [COEF_W-1:0] STRENGTH_FLOOR = 16'd3;

    localparam logic [1:0] MODE_CUSTOM = 2'd0;
    localparam logic [1:0] MODE_BAUER  = 2'd1;
    localparam logic [1:0] MODE_BS2B   = 2'd2;
    localparam logic [1:0] MODE_MEIER  = 2'd3;

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_ISSUE_CG  = 11'b000_0000_0010,
        ST_ISSUE_DG  = 11'b000_0000_0100,
        ST_ISSUE_LPL = 11'b000_0000_1000,
        ST_ISSUE_LPR = 11'b000_0001_0000,
        ST_ISSUE_XL  = 11'b000_0010_0000,
        ST_ISSUE_CL  = 11'b000_0100_0000,
        ST_ISSUE_XR  = 11'b000_1000_0000,
        ST_ISSUE_CR  = 11'b001_0000_0000,
        ST_FINISH    = 11'b010_0000_0000,
        ST_DONE      = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic              active;
        logic [1:0]        mode;
        logic [COEF_W-1:0] strength;   // clamped to 1.0
        logic [LEN_W-1:0]  len;
        logic [COEF_W-1:0] alpha;
        logic              clear;      // delay length write this cycle
    } cfg_t;

    typedef struct packed {
        state_t st;
        logic   load_in;
        logic   load_out;
        logic   wrapped;
    } ctrl_t;

    // Q0.16 gain constants per mode
    function automatic logic [COEF_W-1:0] direct_k(input logic [1:0] m);
        logic [COEF_W-1:0] k;
        unique case (m)
            MODE_CUSTOM: k = 16'd5243;
            MODE_BAUER:  k = 16'd7864;
            MODE_BS2B:   k = 16'd7864;
            MODE_MEIER:  k = 16'd3277;
            default:     k = 16'd5243;
        endcase
        return k;
    endfunction

    function automatic logic [COEF_W-1:0] cross_k(input logic [1:0] m);
        logic [COEF_W-1:0] k;
        unique case (m)
            MODE_CUSTOM: k = 16'd24904;
            MODE_BAUER:  k = 16'd15729;
            MODE_BS2B:   k = 16'd15729;
            MODE_MEIER:  k = 16'd11796;
            default:     k = 16'd24904;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/scm_if.sv
// ----------------------------------------------------------------------------
// scm channel interfaces
// Valid/ready channels for input frames, mixed frames and register writes.
// ----------------------------------------------------------------------------
interface scm_in_if #(
    parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          in_block_end;

    modport source (output valid, output left_sample, output right_sample,
                    output in_block_end, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input in_block_end, output ready);
endinterface

interface scm_out_if #(
    parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          out_block_end;

    modport source (output valid, output left_out, output right_out,
                    output out_block_end, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input out_block_end, output ready);
endinterface

interface scm_cfg_if ();
    logic                             valid;
    logic                             ready;
    logic [scm_pkg::CFG_IDX_W-1:0]    index;
    logic [scm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/scm_ram.sv
// ----------------------------------------------------------------------------
// scm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/scm_cfg.sv
// ----------------------------------------------------------------------------
// scm_cfg
// Register file: enable, mode, strength, delay length and lowpass alpha.
// ----------------------------------------------------------------------------
module scm_cfg #(
    parameter int MAX_DELAY = scm_pkg::MAX_DELAY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_valid,
    input  logic [scm_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [scm_pkg::CFG_DATA_W-1:0]   wr_data,
    output scm_pkg::cfg_t                    cfg
);
    import scm_pkg::*;

    logic              enable_reg;
    logic [1:0]        mode_reg;
    logic [COEF_W-1:0] strength_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [COEF_W-1:0] alpha_reg;
    logic [LEN_W-1:0]  len_next;

    always_comb
    begin
        len_next = wr_data[LEN_W-1:0];
        priority if (len_next == '0)
        begin
            len_next = LEN_W'(1);
        end
        else if (32'(len_next) > MAX_DELAY)
        begin
            len_next = LEN_W'(MAX_DELAY);
        end
        else
        begin
            len_next = wr_data[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            mode_reg     <= MODE_CUSTOM;
            strength_reg <= '0;
            len_reg      <= LEN_W'(1);
            alpha_reg    <= '0;
        end
        else if (wr_valid)
        begin
            unique case (wr_index)
                REG_ENABLE:   enable_reg   <= wr_data[0];
                REG_MODE:     mode_reg     <= wr_data[1:0];
                REG_STRENGTH: strength_reg <= wr_data;
                REG_DELAY:    len_reg      <= len_next;
                REG_ALPHA:    alpha_reg    <= wr_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        cfg.active   = enable_reg && (strength_reg > STRENGTH_FLOOR);
        cfg.mode     = mode_reg;
        cfg.strength = (strength_reg > STRENGTH_ONE) ? STRENGTH_ONE : strength_reg;
        cfg.len      = len_reg;
        cfg.alpha    = alpha_reg;
        cfg.clear    = wr_valid && (wr_index == REG_DELAY);
    end

endmodule

// File: rtl/scm_seq.sv
// ----------------------------------------------------------------------------
// scm_seq
// Frame sequencer: handshakes, multiplier step schedule, delay-line pointer.
// ----------------------------------------------------------------------------
module scm_seq #(
    parameter int MAX_DELAY = scm_pkg::MAX_DELAY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scm_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output scm_pkg::ctrl_t                ctrl,
    output logic                          ram_rd_en,
    output logic                          ram_wr_en,
    output logic [$clog2(MAX_DELAY)-1:0]  ram_addr
);
    import scm_pkg::*;

    localparam int POS_W = $clog2(MAX_DELAY);

    state_t           state_reg, state_next;
    logic [POS_W-1:0] pos_reg;
    logic             wrapped_reg;
    logic             out_valid_reg;
    logic             accept;
    logic             load_out;
    logic [31:0]      pos_inc;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign pos_inc  = 32'(pos_reg) + 32'd1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cfg.active ? ST_ISSUE_CG : ST_DONE;
                end
            end
            ST_ISSUE_CG:  state_next = ST_ISSUE_DG;
            ST_ISSUE_DG:  state_next = ST_ISSUE_LPL;
            ST_ISSUE_LPL: state_next = ST_ISSUE_LPR;
            ST_ISSUE_LPR: state_next = ST_ISSUE_XL;
            ST_ISSUE_XL:  state_next = ST_ISSUE_CL;
            ST_ISSUE_CL:  state_next = ST_ISSUE_XR;
            ST_ISSUE_XR:  state_next = ST_ISSUE_CR;
            ST_ISSUE_CR:  state_next = ST_FINISH;
            ST_FINISH:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // entries read before the first wrap since a clear read as zero
            if (cfg.clear)
            begin
                pos_reg     <= '0;
                wrapped_reg <= 1'b0;
            end
            else if (state_reg == ST_ISSUE_DG)
            begin
                if (pos_inc >= 32'(cfg.len))
                begin
                    pos_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_inc[POS_W-1:0];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign ram_rd_en = (state_reg == ST_ISSUE_CG);
    assign ram_wr_en = (state_reg == ST_ISSUE_DG);
    assign ram_addr  = pos_reg;

    always_comb
    begin
        ctrl.st       = state_reg;
        ctrl.load_in  = accept;
        ctrl.load_out = load_out;
        ctrl.wrapped  = wrapped_reg;
    end

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ISSUE_CG || state_reg == ST_DONE))
        else $error("accepted frame did not start processing");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(cfg.len))
        else $error("delay pointer beyond delay length");

    a_wrap_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wrapped_reg) |-> (pos_reg == '0))
        else $error("wrap flag set away from position zero");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented after completion");

endmodule

// File: rtl/scm_dp.sv
// ----------------------------------------------------------------------------
// scm_dp
// Datapath around one shared 33x17 multiplier: gains, lowpass filters, mix,
// rounding and saturation, and the output payload register.
// ----------------------------------------------------------------------------
module scm_dp #(
    parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scm_pkg::cfg_t                   cfg,
    input  scm_pkg::ctrl_t                  ctrl,
    input  logic signed [SAMPLE_BITS-1:0]   left_sample,
    input  logic signed [SAMPLE_BITS-1:0]   right_sample,
    input  logic                            in_block_end,
    input  logic [2*SAMPLE_BITS-1:0]        ram_rd_data,
    output logic [2*SAMPLE_BITS-1:0]        ram_wr_data,
    output logic signed [SAMPLE_BITS-1:0]   left_out,
    output logic signed [SAMPLE_BITS-1:0]   right_out,
    output logic                            out_block_end
);
    import scm_pkg::*;

    localparam int LP_SHIFT  = LP_W - SAMPLE_BITS;
    localparam int OUT_SHIFT = LP_SHIFT + 15;
    localparam logic signed [PROD_W-1:0] ROUND16 = PROD_W'(32768);
    localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(64'sd1 <<< (OUT_SHIFT - 1));
    localparam logic signed [PROD_W-1:0] SMAX    =
        PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SMIN    = -SMAX - PROD_W'(1);

    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg;
    logic                          end_reg;
    logic signed [SAMPLE_BITS-1:0] dl_reg, dr_reg;
    logic [COEF_W-1:0]             cg_reg, dg_reg;
    logic signed [LP_W-1:0]        lpl_reg, lpr_reg;
    logic signed [PROD_W-1:0]      prod_reg, acc_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg, ro_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;
    logic                          end_out_reg;

    logic signed [MA_W-1:0]        op_a;
    logic signed [MB_W-1:0]        op_b;
    logic signed [LP_W-1:0]        dl_ext, dr_ext;
    logic signed [MA_W-1:0]        diff_l, diff_r;
    logic signed [PROD_W-1:0]      prod_rnd;
    logic signed [PROD_W-1:0]      prod_shl;

    function automatic logic signed [LP_W-1:0] lp_add(
        input logic signed [LP_W-1:0]   lp,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] inc;
        logic signed [PROD_W-1:0] sum;
        inc = (p + ROUND16) >>> 16;
        sum = inc + PROD_W'(lp);
        return sum[LP_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] mix_sat(
        input logic signed [PROD_W-1:0] acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] sum;
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W-1:0] res;
        sum = acc + p + HALF;
        q   = sum >>> OUT_SHIFT;
        priority if (q > SMAX)
        begin
            res = SMAX;
        end
        else if (q < SMIN)
        begin
            res = SMIN;
        end
        else
        begin
            res = q;
        end
        return res[SAMPLE_BITS-1:0];
    endfunction

    assign dl_ext   = LP_W'(dl_reg) <<< LP_SHIFT;
    assign dr_ext   = LP_W'(dr_reg) <<< LP_SHIFT;
    assign diff_l   = MA_W'(dl_ext) - MA_W'(lpl_reg);
    assign diff_r   = MA_W'(dr_ext) - MA_W'(lpr_reg);
    assign prod_rnd = prod_reg + ROUND16;
    assign prod_shl = prod_reg <<< LP_SHIFT;

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (ctrl.st)
            ST_ISSUE_CG:
            begin
                op_a = signed'(MA_W'(cfg.strength));
                op_b = signed'({1'b0, cross_k(cfg.mode)});
            end
            ST_ISSUE_DG:
            begin
                op_a = signed'(MA_W'(cfg.strength));
                op_b = signed'({1'b0, direct_k(cfg.mode)});
            end
            ST_ISSUE_LPL:
            begin
                op_a = diff_l;
                op_b = signed'({1'b0, cfg.alpha});
            end
            ST_ISSUE_LPR:
            begin
                op_a = diff_r;
                op_b = signed'({1'b0, cfg.alpha});
            end
            ST_ISSUE_XL:
            begin
                op_a = MA_W'(l_reg);
                op_b = signed'({1'b0, dg_reg});
            end
            ST_ISSUE_CL:
            begin
                op_a = MA_W'(lpr_reg);
                op_b = signed'({1'b0, cg_reg});
            end
            ST_ISSUE_XR:
            begin
                op_a = MA_W'(r_reg);
                op_b = signed'({1'b0, dg_reg});
            end
            ST_ISSUE_CR:
            begin
                op_a = MA_W'(lpl_reg);
                op_b = signed'({1'b0, cg_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;

        if (ctrl.load_in)
        begin
            l_reg   <= left_sample;
            r_reg   <= right_sample;
            end_reg <= in_block_end;
            lo_reg  <= left_sample;
            ro_reg  <= right_sample;
        end

        unique case (ctrl.st)
            ST_ISSUE_DG:
            begin
                cg_reg <= prod_rnd[31:16];
                dl_reg <= ctrl.wrapped ? ram_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
                dr_reg <= ctrl.wrapped ? ram_rd_data[SAMPLE_BITS-1:0] : '0;
            end
            ST_ISSUE_LPL: dg_reg <= COEF_W'(17'd32768 - 17'(prod_rnd[31:16]));
            ST_ISSUE_CL:  acc_reg <= prod_shl;
            ST_ISSUE_XR:  lo_reg  <= mix_sat(acc_reg, prod_reg);
            ST_ISSUE_CR:  acc_reg <= prod_shl;
            ST_FINISH:    ro_reg  <= mix_sat(acc_reg, prod_reg);
            default:      ;
        endcase

        if (ctrl.load_out)
        begin
            left_out_reg  <= lo_reg;
            right_out_reg <= ro_reg;
            end_out_reg   <= end_reg;
        end
    end

    // filter state; cleared by reset and by a delay length write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpl_reg <= '0;
            lpr_reg <= '0;
        end
        else if (cfg.clear)
        begin
            lpl_reg <= '0;
            lpr_reg <= '0;
        end
        else if (ctrl.st == ST_ISSUE_LPR)
        begin
            lpl_reg <= lp_add(lpl_reg, prod_reg);
        end
        else if (ctrl.st == ST_ISSUE_XL)
        begin
            lpr_reg <= lp_add(lpr_reg, prod_reg);
        end
    end

    assign ram_wr_data   = {l_reg, r_reg};
    assign left_out      = left_out_reg;
    assign right_out     = right_out_reg;
    assign out_block_end = end_out_reg;

endmodule

// File: rtl/stereo_crossfeed_mixer.sv
// ----------------------------------------------------------------------------
// stereo_crossfeed_mixer
// Headphone crossfeed: per-channel delay line, one-pole lowpass, and a
// direct/cross gain mix with saturation.
//
//   channel   role       payload
//   samples   frame in   left_sample, right_sample, in_block_end
//   mixed     frame out  left_out, right_out, out_block_end
//   cfg       reg write  index, data
//
// An active frame runs from accept to the next ready through these steps: eight
// products go one per cycle through the single shared multiplier (the
// delay-line read overlaps the first), then the final round/saturate, the
// output load and the idle state that takes the next frame.
// A pass-through frame goes straight to the output load and the idle state.
// Reset needs no clearing pass: a wrap flag makes unwritten delay entries
// read as zero. The output register lets the next frame be accepted while a
// result still waits; a stalled sink holds the block in its completion step.
// ----------------------------------------------------------------------------
module stereo_crossfeed_mixer #(
    parameter int MAX_DELAY   = scm_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = scm_pkg::SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    scm_in_if.sink    samples,
    scm_out_if.source mixed,
    scm_cfg_if.sink   cfg
);
    import scm_pkg::*;

    localparam int POS_W = $clog2(MAX_DELAY);

    cfg_t                     cfg_s;
    ctrl_t                    ctrl;
    logic                     ram_rd_en;
    logic                     ram_wr_en;
    logic [POS_W-1:0]         ram_addr;
    logic [2*SAMPLE_BITS-1:0] ram_rd_data;
    logic [2*SAMPLE_BITS-1:0] ram_wr_data;

    assign cfg.ready = 1'b1;

    scm_cfg #(
        .MAX_DELAY (MAX_DELAY)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_s)
    );

    scm_seq #(
        .MAX_DELAY (MAX_DELAY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_s),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (mixed.valid),
        .out_ready (mixed.ready),
        .ctrl      (ctrl),
        .ram_rd_en (ram_rd_en),
        .ram_wr_en (ram_wr_en),
        .ram_addr  (ram_addr)
    );

    scm_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_DELAY)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    scm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_s),
        .ctrl          (ctrl),
        .left_sample   (samples.left_sample),
        .right_sample  (samples.right_sample),
        .in_block_end  (samples.in_block_end),
        .ram_rd_data   (ram_rd_data),
        .ram_wr_data   (ram_wr_data),
        .left_out      (mixed.left_out),
        .right_out     (mixed.right_out),
        .out_block_end (mixed.out_block_end)
    );

endmodule

// File: verif/stereo_crossfeed_mixer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_crossfeed_mixer_test
// Self-checking bench for the crossfeed mixer. A directed table covers the
// sample extremes, saturation, every gain preset, the inactive threshold and
// delay length clamping and clearing. Random segments follow with random
// register settings and random backpressure on both channels. Every mixed
// frame is compared against its table value or a bit-accurate local model
// of the delay lines, lowpass filters and gain mix.
// ----------------------------------------------------------------------------
module stereo_crossfeed_mixer_test;

    import scm_pkg::*;

    localparam int SB     = SAMPLE_BITS_DEF;
    localparam int DEPTH  = MAX_DELAY_DEF;
    localparam int LPW    = LP_W;
    localparam int SHIFT  = LPW - SB;
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    // indexes 5..7 decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

    localparam int SEGMENT_FRAMES = 34;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic signed [SB-1:0] left_smp;
        logic signed [SB-1:0] right_smp;
        logic                 blk_end;
    } frame_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        frame_t                frame;
        logic                  typed;
        frame_t                want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    scm_in_if  #(.SAMPLE_BITS(SB)) samples_ch ();
    scm_out_if #(.SAMPLE_BITS(SB)) mixed_ch ();
    scm_cfg_if                     cfg_ch ();

    stereo_crossfeed_mixer #(
        .MAX_DELAY   (DEPTH),
        .SAMPLE_BITS (SB)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .mixed   (mixed_ch),
        .cfg     (cfg_ch)
    );

    // local copy of registers and filter state
    logic                 cfg_en;
    logic [1:0]           cfg_mode;
    int                   cfg_strength;
    int                   cfg_len;
    int                   cfg_alpha;
    logic signed [SB-1:0] left_line  [DEPTH];
    logic signed [SB-1:0] right_line [DEPTH];
    int                   tap;
    logic signed [LPW-1:0] left_lp;
    logic signed [LPW-1:0] right_lp;

    frame_t    expected_mix [$];
    plan_row_t plan [$];

    int  errors        = 0;
    int  frames_sent   = 0;
    int  frames_seen   = 0;
    int  reg_writes    = 0;
    int  in_idle_pct   = 0;
    int  out_idle_pct  = 0;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t with %0d frames outstanding", $time, expected_mix.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // local model
    // ------------------------------------------------------------------------
    function automatic void clear_lines();
        foreach (left_line[i])
        begin
            left_line[i]  = '0;
            right_line[i] = '0;
        end
        tap      = 0;
        left_lp  = '0;
        right_lp = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        int v;
        case (idx)
            REG_ENABLE:   cfg_en = data[0];
            REG_MODE:     cfg_mode = data[1:0];
            REG_STRENGTH: cfg_strength = int'(data);
            REG_ALPHA:    cfg_alpha = int'(data);
            REG_DELAY:
            begin
                v = int'(data[LEN_W-1:0]);
                if (v < 1)
                    v = 1;
                if (v > DEPTH)
                    v = DEPTH;
                cfg_len = v;
                clear_lines();
            end
            default: ;
        endcase
    endfunction

    // lp += round(alpha * (delayed - lp) / 2^16), floor rounding of the sum
    function automatic logic signed [LPW-1:0] lowpass_next(input logic signed [LPW-1:0] lp,
                                                           input logic signed [SB-1:0] delayed);
        longint diff;
        longint inc;
        diff = (longint'(delayed) <<< SHIFT) - longint'(lp);
        inc  = (diff * longint'(cfg_alpha) + 64'sd32768) >>> 16;
        return LPW'(longint'(lp) + inc);
    endfunction

    function automatic logic signed [SB-1:0] mix_sat(input logic signed [SB-1:0] x,
                                                     input longint dg,
                                                     input logic signed [LPW-1:0] lp,
                                                     input longint cg);
        longint acc;
        longint q;
        acc = (longint'(x) <<< SHIFT) * dg + longint'(lp) * cg;
        q   = (acc + (64'sd1 <<< (SHIFT + 14))) >>> (SHIFT + 15);
        if (q > longint'(S_MAX))
            q = longint'(S_MAX);
        else if (q < longint'(S_MIN))
            q = longint'(S_MIN);
        return q[SB-1:0];
    endfunction

    function automatic frame_t predict_mix(input frame_t f);
        frame_t               r;
        longint               s;
        longint               kd;
        longint               kc;
        longint               dg;
        longint               cg;
        logic signed [SB-1:0] dl;
        logic signed [SB-1:0] dr;
        r = f;
        if (cfg_en && cfg_strength > int'(STRENGTH_FLOOR))
        begin
            s = (cfg_strength > int'(STRENGTH_ONE)) ? longint'(STRENGTH_ONE) : cfg_strength;
            case (cfg_mode)
                MODE_CUSTOM: begin kd = 5243; kc = 24904; end
                MODE_BAUER:  begin kd = 7864; kc = 15729; end
                MODE_BS2B:   begin kd = 7864; kc = 15729; end
                default:     begin kd = 3277; kc = 11796; end
            endcase
            dg = 32768 - ((kd * s + 32768) >>> 16);
            cg = (kc * s + 32768) >>> 16;
            dl = left_line[tap];
            dr = right_line[tap];
            left_line[tap]  = f.left_smp;
            right_line[tap] = f.right_smp;
            tap = tap + 1;
            if (tap >= cfg_len)
                tap = 0;
            left_lp  = lowpass_next(left_lp, dl);
            right_lp = lowpass_next(right_lp, dr);
            r.left_smp  = mix_sat(f.left_smp, dg, right_lp, cg);
            r.right_smp = mix_sat(f.right_smp, dg, left_lp, cg);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic frame_t make_frame(input int l, input int r, input bit e);
        frame_t f;
        f.left_smp  = SB'(l);
        f.right_smp = SB'(r);
        f.blk_end   = e;
        return f;
    endfunction

    function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        plan_row_t p;
        p        = '0;
        p.is_reg = 1'b1;
        p.idx    = idx;
        p.data   = data;
        plan.push_back(p);
    endfunction

    function automatic void frame_row(input int l, input int r, input bit e);
        plan_row_t p;
        p       = '0;
        p.frame = make_frame(l, r, e);
        plan.push_back(p);
    endfunction

    function automatic void known_row(input int l, input int r, input bit e,
                                      input int wl, input int wr);
        plan_row_t p;
        p       = '0;
        p.frame = make_frame(l, r, e);
        p.typed = 1'b1;
        p.want  = make_frame(wl, wr, e);
        plan.push_back(p);
    endfunction

    function automatic logic signed [SB-1:0] pick_sample();
        logic signed [SB-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = S_MAX;
            1:       v = S_MIN;
            2:       v = '0;
            3, 4:    v = SB'(int'($urandom_range(0, 2000)) - 1000);
            default: v = SB'($urandom());
        endcase
        return v;
    endfunction

    task automatic offer_frame(input frame_t f, input bit typed, input frame_t want);
        frame_t got;
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        got = predict_mix(f);
        samples_ch.valid        <= 1'b1;
        samples_ch.left_sample  <= f.left_smp;
        samples_ch.right_sample <= f.right_smp;
        samples_ch.in_block_end <= f.blk_end;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        expected_mix.push_back(typed ? want : got);
        frames_sent++;
    endtask

    // registers change only with the block drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        samples_ch.valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        apply_reg(idx, data);
        reg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // result side: random ready, long hold on request, compare
    // ------------------------------------------------------------------------
    initial
    begin
        frame_t want;
        mixed_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (mixed_ch.valid && mixed_ch.ready)
            begin
                frames_seen++;
                if (expected_mix.size() == 0)
                begin
                    $display("%0t: unexpected frame %0d/%0d end %0d", $time,
                             mixed_ch.left_out, mixed_ch.right_out, mixed_ch.out_block_end);
                    errors++;
                end
                else
                begin
                    want = expected_mix.pop_front();
                    if (mixed_ch.left_out !== want.left_smp)
                    begin
                        $display("%0t: left_out expected %0d actual %0d", $time,
                                 want.left_smp, mixed_ch.left_out);
                        errors++;
                    end
                    if (mixed_ch.right_out !== want.right_smp)
                    begin
                        $display("%0t: right_out expected %0d actual %0d", $time,
                                 want.right_smp, mixed_ch.right_out);
                        errors++;
                    end
                    if (mixed_ch.out_block_end !== want.blk_end)
                    begin
                        $display("%0t: out_block_end expected %0d actual %0d", $time,
                                 want.blk_end, mixed_ch.out_block_end);
                        errors++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                mixed_ch.ready <= 1'b0;
            end
            else
                mixed_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        frame_t none;
        int     phase;
        int     seg;
        int     k;
        none = '0;

        rst_n                   <= 1'b0;
        samples_ch.valid        <= 1'b0;
        samples_ch.left_sample  <= '0;
        samples_ch.right_sample <= '0;
        samples_ch.in_block_end <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= REG_ENABLE;
        cfg_ch.data             <= '0;

        cfg_en       = 1'b0;
        cfg_mode     = MODE_CUSTOM;
        cfg_strength = 0;
        cfg_len      = 1;
        cfg_alpha    = 0;
        clear_lines();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of reset the block is disabled: frames pass untouched
        known_row(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN);
        known_row(S_MIN, S_MAX, 1'b0, S_MIN, S_MAX);
        known_row(0, -1, 1'b1, 0, -1);
        reg_row(REG_STRENGTH, STRENGTH_ONE);
        reg_row(REG_ALPHA, 16'hFFFF);
        reg_row(REG_MODE, 16'(MODE_CUSTOM));
        reg_row(REG_ENABLE, 16'd1);
        reg_row(REG_DELAY, 16'd1);
        // full scale on both channels drives the mix past full scale
        frame_row(S_MAX, S_MAX, 1'b0);
        known_row(S_MAX, S_MAX, 1'b1, S_MAX, S_MAX);
        known_row(S_MAX, S_MAX, 1'b0, S_MAX, S_MAX);
        frame_row(S_MIN, S_MIN, 1'b0);
        known_row(S_MIN, S_MIN, 1'b0, S_MIN, S_MIN);
        known_row(S_MIN, S_MIN, 1'b1, S_MIN, S_MIN);
        // strength at the floor is inactive, state held
        reg_row(REG_STRENGTH, STRENGTH_FLOOR);
        known_row(12345, -54321, 1'b0, 12345, -54321);
        reg_row(REG_STRENGTH, STRENGTH_FLOOR + 16'd1);
        frame_row(1000000, -2000000, 1'b0);
        reg_row(REG_MODE, 16'(MODE_BAUER));
        frame_row(-3000000, 2500000, 1'b1);
        reg_row(REG_MODE, 16'(MODE_BS2B));
        frame_row(777777, 4194304, 1'b0);
        reg_row(REG_MODE, 16'(MODE_MEIER));
        frame_row(-4194304, -1, 1'b0);
        reg_row(REG_ENABLE, 16'd0);
        known_row(-1, 1, 1'b1, -1, 1);
        reg_row(REG_ENABLE, 16'd1);
        // rewriting the same length still clears the lines
        reg_row(REG_DELAY, 16'd1);
        frame_row(5000000, -5000000, 1'b0);
        reg_row(REG_DELAY, 16'd0);
        frame_row(S_MAX, 3, 1'b0);
        frame_row(-7, S_MIN, 1'b1);
        reg_row(REG_DELAY, 16'd512);
        reg_row(REG_ALPHA, 16'd0);
        frame_row(S_MAX, S_MIN, 1'b0);
        reg_row(REG_DELAY, 16'd1023);
        reg_row(REG_ALPHA, 16'd40000);
        frame_row(6000000, 100, 1'b0);
        reg_row(REG_STRENGTH, 16'hFFFF);
        frame_row(-6000000, 8000000, 1'b1);
        reg_row(REG_SPARE, 16'hFFFF);
        frame_row(123, -456, 1'b0);
        reg_row(REG_DELAY, 16'd3);
        reg_row(REG_ALPHA, 16'd32768);
        reg_row(REG_MODE, 16'(MODE_CUSTOM));
        frame_row(S_MAX, S_MAX, 1'b0);
        frame_row(S_MIN, 0, 1'b0);
        frame_row(0, S_MAX, 1'b1);
        frame_row(2000000, -2000000, 1'b0);

        in_idle_pct  = 8;
        out_idle_pct = 79;
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
                write_reg(plan[i].idx, plan[i].data);
            else
                offer_frame(plan[i].frame, plan[i].typed, plan[i].want);
        end

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase / 2)
                0:       begin in_idle_pct = 8;  out_idle_pct = 79; end
                1:       begin in_idle_pct = 79; out_idle_pct = 8;  end
                default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
            endcase
            for (seg = 0; seg < 5; seg++)
            begin
                if (seg == 0 || $urandom_range(0, 1))
                    write_reg(REG_ENABLE, ($urandom_range(0, 9) != 0) ? 16'd1 : 16'd0);
                if (seg == 0 || $urandom_range(0, 1))
                    write_reg(REG_MODE, 16'($urandom_range(0, 3)));
                if (seg == 0 || $urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 5))
                        0:       write_reg(REG_STRENGTH, 16'($urandom_range(0, 3)));
                        1:       write_reg(REG_STRENGTH, STRENGTH_ONE);
                        2:       write_reg(REG_STRENGTH, 16'($urandom_range(32769, 65535)));
                        3:       write_reg(REG_STRENGTH, STRENGTH_FLOOR + 16'd1);
                        default: write_reg(REG_STRENGTH, 16'($urandom_range(4, 32768)));
                    endcase
                end
                if (seg == 0 || $urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 3))
                        0:       write_reg(REG_ALPHA, 16'd0);
                        1:       write_reg(REG_ALPHA, 16'hFFFF);
                        default: write_reg(REG_ALPHA, 16'($urandom()));
                    endcase
                end
                if (seg == 0 || $urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       write_reg(REG_DELAY, 16'd512);
                        1:       write_reg(REG_DELAY, 16'($urandom_range(513, 1023)));
                        2:       write_reg(REG_DELAY, 16'd0);
                        default: write_reg(REG_DELAY, 16'($urandom_range(1, 24)));
                    endcase
                end
                if ($urandom_range(0, 7) == 0)
                    write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 16'($urandom()));

                // stall the output long enough to back up the input
                if ((phase == 1 && seg == 2) || (phase == 4 && seg == 0))
                    hold_request = 1'b1;

                for (k = 0; k < SEGMENT_FRAMES; k++)
                    offer_frame(make_frame(pick_sample(), pick_sample(),
                                           $urandom_range(0, 1)), 1'b0, none);
            end
        end

        samples_ch.valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("%0d frames sent, %0d checked, %0d register writes", frames_sent,
                 frames_seen, reg_writes);
        $display("covered pass-through, all presets, delay clamping and clears, backpressure");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
